>>> hw/rtl/irpr_pkg.sv
// Types, constants and helper functions for the IR pulse recorder.
`default_nettype none

package irpr_pkg;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_MARK  = 5'b00010,
        PH_SPACE = 5'b00100,
        PH_STOP  = 5'b01000,
        PH_OVER  = 5'b10000
    } phase_t;

    localparam logic [2:0] CODE_IDLE  = 3'd0;
    localparam logic [2:0] CODE_MARK  = 3'd1;
    localparam logic [2:0] CODE_SPACE = 3'd2;
    localparam logic [2:0] CODE_STOP  = 3'd3;
    localparam logic [2:0] CODE_OVER  = 3'd4;

    localparam logic [1:0] CMP_SHORTER = 2'd0;
    localparam logic [1:0] CMP_SIMILAR = 2'd1;
    localparam logic [1:0] CMP_LONGER  = 2'd2;

    localparam logic [7:0] REG_GAP_TICKS   = 8'd0;
    localparam logic [7:0] REG_MAX_ENTRIES = 8'd1;

    localparam logic [15:0] GAP_TICKS_RESET   = 16'd100;
    localparam logic [7:0]  MAX_ENTRIES_RESET = 8'd101;

    localparam logic [31:0] HASH_PRIME       = 32'd16777619;
    localparam logic [31:0] HASH_BASIS       = 32'd2166136261;
    localparam logic [7:0]  HASH_MIN_ENTRIES = 8'd6;
    localparam logic [7:0]  HASH_START_INDEX = 8'd3;
    localparam logic [15:0] TICK_MAX         = 16'hFFFF;

    function automatic logic [2:0] phase_code_f(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:  code = CODE_IDLE;
            PH_MARK:  code = CODE_MARK;
            PH_SPACE: code = CODE_SPACE;
            PH_STOP:  code = CODE_STOP;
            PH_OVER:  code = CODE_OVER;
            default:  code = CODE_IDLE;
        endcase
        return code;
    endfunction

    // ratio test without floats: b < 0.8a, else a < 0.8b
    function automatic logic [1:0] cmp_durations(input logic [15:0] a, input logic [15:0] b);
        logic [18:0] a5;
        logic [18:0] b5;
        logic [18:0] a4;
        logic [18:0] b4;
        logic [1:0]  res;
        a5 = 19'(a) * 19'd5;
        b5 = 19'(b) * 19'd5;
        a4 = {1'b0, a, 2'b00};
        b4 = {1'b0, b, 2'b00};
        if (b5 < a4) begin
            res = CMP_SHORTER;
        end
        else if (a5 < b4) begin
            res = CMP_LONGER;
        end
        else begin
            res = CMP_SIMILAR;
        end
        return res;
    endfunction

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [1:0] c);
        logic [31:0] prod;
        prod = h * HASH_PRIME;
        return prod ^ {30'd0, c};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ir_pulse_recorder_with_hash.sv
// Top level of the IR pulse recorder with running pattern hash.
`default_nettype none

// One item per clock cycle, sustained while the output is not stalled. An
// accepted item sits in the input register; once the result register is free,
// the single state-update stage decides the phase, timing and hash and loads the
// result register, so a result passes both registers in turn. The hash multiply
// by the FNV prime is a constant multiply inside that stage. Configuration
// writes are always ready and take effect on the next item processed.
module ir_pulse_recorder_with_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic        is_mark,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       phase_code,
    output logic             is_idle,
    output logic             recorded,
    output logic [15:0]      duration,
    output logic [7:0]       duration_index,
    output logic [7:0]       entry_count,
    output logic             overflowed,
    output logic [31:0]      pattern_hash,
    output logic             hash_valid,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import irpr_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_op_reg;
    logic        s1_mark_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_take;
    logic        advance;

    logic [15:0] gap_ticks_reg;
    logic [7:0]  max_entries_reg;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] tick_reg;
    logic [15:0] tick_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic [15:0] older_reg;
    logic [15:0] older_next;
    logic [15:0] prior_reg;
    logic [15:0] prior_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    phase_t      ph_work;
    logic [7:0]  thr;
    logic        rec;
    logic        start;
    logic [15:0] dur;
    logic [7:0]  didx;
    logic [7:0]  cnt_base;
    logic [15:0] older_base;
    logic [15:0] prior_base;
    logic [31:0] hash_base;

    logic [2:0]  phase_code_reg;
    logic        is_idle_reg;
    logic        recorded_reg;
    logic [15:0] duration_reg;
    logic [7:0]  duration_index_reg;
    logic [7:0]  entry_count_reg;
    logic        overflowed_reg;
    logic [31:0] pattern_hash_reg;
    logic        hash_valid_reg;

    // handshake
    assign advance        = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall       = s1_valid_reg & out_valid_reg & out_stall;
    assign in_take        = in_valid & ~in_stall;
    assign s1_valid_next  = in_take | (s1_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & out_stall);
    assign cfg_ready      = 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        older_next = older_reg;
        prior_next = prior_reg;
        hash_next  = hash_reg;
        ph_work    = phase_reg;
        thr        = (max_entries_reg == 8'd0) ? 8'd0 : max_entries_reg - 8'd1;
        rec        = 1'b0;
        start      = 1'b0;
        dur        = 16'd0;
        didx       = 8'd0;
        cnt_base   = count_reg;
        older_base = older_reg;
        prior_base = prior_reg;
        hash_base  = hash_reg;

        if (s1_op_reg)
        begin
            phase_next = PH_IDLE;
            count_next = 8'd0;
        end
        else
        begin
            tick_next  = (tick_reg != TICK_MAX) ? tick_reg + 16'd1 : tick_reg;
            ph_work    = (count_reg >= thr) ? PH_OVER : phase_reg;
            phase_next = ph_work;
            case (ph_work)
                PH_IDLE:
                begin
                    if (s1_mark_reg)
                    begin
                        if (tick_next < gap_ticks_reg)
                        begin
                            tick_next = 16'd0;
                        end
                        else
                        begin
                            start      = 1'b1;
                            rec        = 1'b1;
                            phase_next = PH_MARK;
                        end
                    end
                end
                PH_MARK:
                begin
                    if (!s1_mark_reg)
                    begin
                        rec        = 1'b1;
                        phase_next = PH_SPACE;
                    end
                end
                PH_SPACE:
                begin
                    if (s1_mark_reg)
                    begin
                        rec        = 1'b1;
                        phase_next = PH_MARK;
                    end
                    else if (tick_next > gap_ticks_reg)
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (s1_mark_reg)
                    begin
                        tick_next = 16'd0;
                    end
                end
                PH_OVER:
                begin
                    ovf_next   = 1'b1;
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // new frame clears history before slot 0
            if (start)
            begin
                cnt_base   = 8'd0;
                older_base = 16'd0;
                prior_base = 16'd0;
                hash_base  = HASH_BASIS;
                ovf_next   = 1'b0;
                hash_next  = HASH_BASIS;
                count_next = 8'd0;
                older_next = 16'd0;
                prior_next = 16'd0;
            end

            if (rec)
            begin
                dur        = tick_next;
                didx       = cnt_base;
                hash_next  = (cnt_base >= HASH_START_INDEX)
                             ? hash_step(hash_base, cmp_durations(older_base, dur))
                             : hash_base;
                older_next = prior_base;
                prior_next = dur;
                count_next = cnt_base + 8'd1;
                tick_next  = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            gap_ticks_reg   <= GAP_TICKS_RESET;
            max_entries_reg <= MAX_ENTRIES_RESET;
            phase_reg       <= PH_IDLE;
            tick_reg        <= 16'd0;
            count_reg       <= 8'd0;
            ovf_reg         <= 1'b0;
            older_reg       <= 16'd0;
            prior_reg       <= 16'd0;
            hash_reg        <= HASH_BASIS;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAP_TICKS)
                begin
                    gap_ticks_reg <= cfg_data;
                end
                else if (cfg_index == REG_MAX_ENTRIES)
                begin
                    max_entries_reg <= cfg_data[7:0];
                end
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
                older_reg <= older_next;
                prior_reg <= prior_next;
                hash_reg  <= hash_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg   <= op;
            s1_mark_reg <= is_mark;
        end
        if (advance)
        begin
            phase_code_reg     <= phase_code_f(phase_next);
            is_idle_reg        <= (phase_next == PH_IDLE) || (phase_next == PH_STOP);
            recorded_reg       <= rec;
            duration_reg       <= dur;
            duration_index_reg <= didx;
            entry_count_reg    <= count_next;
            overflowed_reg     <= ovf_next;
            pattern_hash_reg   <= hash_next;
            hash_valid_reg     <= (count_next >= HASH_MIN_ENTRIES);
        end
    end

    assign out_valid      = out_valid_reg;
    assign phase_code     = phase_code_reg;
    assign is_idle        = is_idle_reg;
    assign recorded       = recorded_reg;
    assign duration       = duration_reg;
    assign duration_index = duration_index_reg;
    assign entry_count    = entry_count_reg;
    assign overflowed     = overflowed_reg;
    assign pattern_hash   = pattern_hash_reg;
    assign hash_valid     = hash_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/irpr_checker.sv
// Port-level assertion checker for the IR pulse recorder, with its bind.
`default_nettype none

module irpr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  phase_code,
    input wire logic        is_idle,
    input wire logic        recorded,
    input wire logic [15:0] duration,
    input wire logic [7:0]  duration_index,
    input wire logic [7:0]  entry_count,
    input wire logic        hash_valid
);
    import irpr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_idle == ((phase_code == CODE_IDLE) || (phase_code == CODE_STOP))))
        else $error("is_idle disagrees with phase_code");

    a_hash_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hash_valid == (entry_count >= HASH_MIN_ENTRIES)))
        else $error("hash_valid disagrees with entry_count");

    a_slot_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && recorded |-> (entry_count == 8'(duration_index + 8'd1)))
        else $error("slot index not one below entry count");

    a_no_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !recorded |-> (duration == 16'd0) && (duration_index == 8'd0)
                                   && (phase_code != CODE_OVER))
        else $error("non-recording result carries a duration");

endmodule

bind ir_pulse_recorder_with_hash irpr_checker u_irpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .phase_code     (phase_code),
    .is_idle        (is_idle),
    .recorded       (recorded),
    .duration       (duration),
    .duration_index (duration_index),
    .entry_count    (entry_count),
    .hash_valid     (hash_valid)
);

`default_nettype wire

>>> dv/irpr_frame_checker.sv
// Watches the IR recorder channels, predicts each result and compares it field by field.
`timescale 1ns / 1ps

module irpr_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic        is_mark,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  phase_code,
    input  logic        is_idle,
    input  logic        recorded,
    input  logic [15:0] duration,
    input  logic [7:0]  duration_index,
    input  logic [7:0]  entry_count,
    input  logic        overflowed,
    input  logic [31:0] pattern_hash,
    input  logic        hash_valid,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    import irpr_pkg::*;

    typedef struct packed {
        logic [2:0]  phase_code;
        logic        is_idle;
        logic        recorded;
        logic [15:0] duration;
        logic [7:0]  duration_index;
        logic [7:0]  entry_count;
        logic        overflowed;
        logic [31:0] pattern_hash;
        logic        hash_valid;
    } rx_result_t;

    rx_result_t  due_results[$];

    logic [15:0] gap_cfg;
    logic [7:0]  max_cfg;
    phase_t      rx_phase;
    logic [15:0] ticks;
    logic [7:0]  slots;
    logic        ovf;
    logic [15:0] dur_older;
    logic [15:0] dur_prior;
    logic [31:0] hash_run;

    function automatic logic [1:0] ratio_class(input logic [15:0] a, input logic [15:0] b);
        int unsigned ua;
        int unsigned ub;
        ua = a;
        ub = b;
        if (5 * ub < 4 * ua)
            return CMP_SHORTER;
        if (5 * ua < 4 * ub)
            return CMP_LONGER;
        return CMP_SIMILAR;
    endfunction

    // closes the interval just timed: hash fold from HASH_START_INDEX on, shift the held pair, next slot
    function automatic void close_interval(inout rx_result_t r);
        r.recorded       = 1'b1;
        r.duration       = ticks;
        r.duration_index = slots;
        if (slots >= HASH_START_INDEX)
            hash_run = (hash_run * HASH_PRIME) ^ {30'd0, ratio_class(dur_older, ticks)};
        dur_older = dur_prior;
        dur_prior = ticks;
        slots     = slots + 8'd1;
        ticks     = '0;
    endfunction

    function automatic rx_result_t advance_recorder(input logic resume, input logic mark);
        rx_result_t r;
        logic [7:0] limit;
        r = '0;
        if (resume)
        begin
            rx_phase = PH_IDLE;
            slots    = '0;
        end
        else
        begin
            limit = (max_cfg != 8'd0) ? max_cfg - 8'd1 : 8'd0;
            if (ticks != TICK_MAX)
                ticks = ticks + 16'd1;
            if (slots >= limit)
                rx_phase = PH_OVER;
            case (rx_phase)
                PH_IDLE:
                begin
                    if (mark)
                    begin
                        if (ticks < gap_cfg)
                        begin
                            ticks = '0;
                        end
                        else
                        begin
                            ovf       = 1'b0;
                            slots     = '0;
                            hash_run  = HASH_BASIS;
                            dur_older = '0;
                            dur_prior = '0;
                            close_interval(r);
                            rx_phase  = PH_MARK;
                        end
                    end
                end
                PH_MARK:
                begin
                    if (!mark)
                    begin
                        close_interval(r);
                        rx_phase = PH_SPACE;
                    end
                end
                PH_SPACE:
                begin
                    if (mark)
                    begin
                        close_interval(r);
                        rx_phase = PH_MARK;
                    end
                    else if (ticks > gap_cfg)
                    begin
                        rx_phase = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (mark)
                        ticks = '0;
                end
                PH_OVER:
                begin
                    ovf      = 1'b1;
                    rx_phase = PH_STOP;
                end
                default:
                begin
                end
            endcase
        end
        case (rx_phase)
            PH_MARK:  r.phase_code = CODE_MARK;
            PH_SPACE: r.phase_code = CODE_SPACE;
            PH_STOP:  r.phase_code = CODE_STOP;
            PH_OVER:  r.phase_code = CODE_OVER;
            default:  r.phase_code = CODE_IDLE;
        endcase
        r.is_idle      = (rx_phase == PH_IDLE) || (rx_phase == PH_STOP);
        r.entry_count  = slots;
        r.overflowed   = ovf;
        r.pattern_hash = hash_run;
        r.hash_valid   = (slots >= HASH_MIN_ENTRIES);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rx_result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            gap_cfg     = GAP_TICKS_RESET;
            max_cfg     = MAX_ENTRIES_RESET;
            rx_phase    = PH_IDLE;
            ticks       = '0;
            slots       = '0;
            ovf         = 1'b0;
            dur_older   = '0;
            dur_prior   = '0;
            hash_run    = HASH_BASIS;
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GAP_TICKS)
                    gap_cfg = cfg_data;
                else if (cfg_index == REG_MAX_ENTRIES)
                    max_cfg = cfg_data[7:0];
            end
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t ns: result transfer with none expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("phase_code", want.phase_code, phase_code);
                    check_field("is_idle", want.is_idle, is_idle);
                    check_field("recorded", want.recorded, recorded);
                    check_field("duration", want.duration, duration);
                    check_field("duration_index", want.duration_index, duration_index);
                    check_field("entry_count", want.entry_count, entry_count);
                    check_field("overflowed", want.overflowed, overflowed);
                    check_field("pattern_hash", want.pattern_hash, pattern_hash);
                    check_field("hash_valid", want.hash_valid, hash_valid);
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(advance_recorder(op, is_mark));
            outstanding = due_results.size();
        end
    end

endmodule

>>> dv/ir_pulse_recorder_with_hash_test.sv
// Stimulus and verdict for the IR pulse recorder, checked by irpr_frame_checker.
`timescale 1ns / 1ps

module ir_pulse_recorder_with_hash_test;
    import irpr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 140;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic        is_mark = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  phase_code;
    logic        is_idle;
    logic        recorded;
    logic [15:0] duration;
    logic [7:0]  duration_index;
    logic [7:0]  entry_count;
    logic        overflowed;
    logic [31:0] pattern_hash;
    logic        hash_valid;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          quiet_cycles = 0;
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    int unsigned sent_items = 0;
    int unsigned gap_now = GAP_TICKS_RESET;

    int unsigned gap_table [8] = '{1, 2, 5, 3, 16, 1, 7, 12};
    int unsigned max_table [8] = '{4, 255, 12, 101, 30, 255, 8, 4};
    int unsigned idle_table [4] = '{0, 50, 0, 37};
    int unsigned stall_table [4] = '{0, 0, 50, 37};

    ir_pulse_recorder_with_hash u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .is_mark        (is_mark),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_code     (phase_code),
        .is_idle        (is_idle),
        .recorded       (recorded),
        .duration       (duration),
        .duration_index (duration_index),
        .entry_count    (entry_count),
        .overflowed     (overflowed),
        .pattern_hash   (pattern_hash),
        .hash_valid     (hash_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    irpr_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .is_mark        (is_mark),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_code     (phase_code),
        .is_idle        (is_idle),
        .recorded       (recorded),
        .duration       (duration),
        .duration_index (duration_index),
        .entry_count    (entry_count),
        .overflowed     (overflowed),
        .pattern_hash   (pattern_hash),
        .hash_valid     (hash_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)
                       || (cfg_valid && cfg_ready)))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    task automatic send_item(input logic resume, input logic level);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= resume;
        is_mark  <= level;
        do @(posedge clk); while (in_stall);
        sent_items++;
    endtask

    task automatic send_run(input logic level, input int unsigned n);
        repeat (n) send_item(1'b0, level);
    endtask

    task automatic settle_outputs();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input int unsigned gap, input int unsigned slots);
        program_register(REG_GAP_TICKS, 16'(gap));
        program_register(REG_MAX_ENTRIES, {8'h00, 8'(slots)});
        cfg_valid <= 1'b0;
        gap_now = gap;
    endtask

    function automatic int unsigned vary_length(input int unsigned base);
        case ($urandom_range(3))
            0:       return base;
            1:       return base + base / 4;
            2:       return base * 2;
            default: return (base + 1) / 2;
        endcase
    endfunction

    // gap, a train of marks and spaces, a stopping space, then mostly a resume
    task automatic send_frame();
        int unsigned pulses;
        int unsigned base;
        int unsigned mark_len;
        int unsigned space_len;
        send_run(1'b0, gap_now + $urandom_range(0, 3));
        pulses = $urandom_range(1, 14);
        base   = $urandom_range(1, 6);
        repeat (pulses)
        begin
            mark_len  = vary_length(base);
            space_len = vary_length(base);
            if (space_len > gap_now && $urandom_range(3) != 0)
                space_len = gap_now;
            send_run(1'b1, mark_len);
            send_run(1'b0, space_len);
        end
        send_run(1'b0, gap_now + 1);
        if ($urandom_range(9) != 0)
            send_item(1'b1, 1'($urandom_range(1)));
    endtask

    initial
    begin
        int unsigned phase_start;
        int unsigned pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: short frame up to overflow, a stopped mark, resume
        program_register(8'hFE, 16'hFFFF);
        apply_settings(3, 6);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b1);
        send_run(1'b0, 3);
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        send_run(1'b1, 5);
        send_run(1'b0, 4);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        settle_outputs();

        // zero slots: every tick overflows
        apply_settings(3, 0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);

        for (int mode = 0; mode < 4; mode++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                settle_outputs();
                pick = mode * 2 + k;
                apply_settings(gap_table[pick], max_table[pick]);
                send_idle   = idle_table[mode];
                recv_stall  = stall_table[mode];
                phase_start = sent_items;
                while (sent_items - phase_start < PHASE_ITEMS)
                begin
                    if ($urandom_range(9) < 8)
                    begin
                        send_frame();
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 8))
                            send_item($urandom_range(15) == 0, 1'($urandom_range(1)));
                    end
                    if ($urandom_range(39) == 0)
                        settle_outputs();
                end
            end
        end

        // long silence against a wide gap
        settle_outputs();
        send_idle  = 0;
        recv_stall = 0;
        apply_settings(80, 255);
        send_item(1'b1, 1'b0);
        send_run(1'b0, 90);
        send_run(1'b1, 20);
        send_run(1'b0, 5);
        settle_outputs();

        @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/irpr_pkg.sv
hw/rtl/ir_pulse_recorder_with_hash.sv
hw/rtl/irpr_checker.sv
dv/irpr_frame_checker.sv
dv/ir_pulse_recorder_with_hash_test.sv
